FILE: src/bpq_pkg.sv
// ----------------------------------------------------------------------------
// bpq_pkg
// shared types, register indexes, action codes and reset values for the
// button press qualifier
// ----------------------------------------------------------------------------
package bpq_pkg;

	localparam int COUNT_WIDTH_DEFAULT = 20;

	// configuration port geometry
	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 20;

	// field widths of the configuration registers
	localparam int DEBOUNCE_W = 10;
	localparam int LONG_W     = 16;
	localparam int IDLE_W     = 20;
	localparam int REFRESH_W  = 16;

	// reset values of the configuration registers
	localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 10'd40;
	localparam logic [LONG_W-1:0]     LONG_RESET     = 16'd1500;
	localparam logic [IDLE_W-1:0]     IDLE_RESET     = 20'd60000;
	localparam logic [REFRESH_W-1:0]  REFRESH_RESET  = 16'd5000;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_DEBOUNCE = 4'd0,
		REG_LONG     = 4'd1,
		REG_IDLE     = 4'd2,
		REG_REFRESH  = 4'd3
	} reg_index_t;

	typedef enum logic [1:0] {
		ACT_NONE   = 2'd0,
		ACT_ALERT  = 2'd1,
		ACT_READY  = 2'd2,
		ACT_TOGGLE = 2'd3
	} action_t;

	localparam logic PAGE_HOME = 1'b0;
	localparam logic PAGE_INFO  = 1'b1;
	localparam logic LVL_PRESSED  = 1'b0;
	localparam logic LVL_RELEASED = 1'b1;

	typedef struct packed {
		logic [DEBOUNCE_W-1:0] debounce_ticks;
		logic [LONG_W-1:0]     long_press_ticks;
		logic [IDLE_W-1:0]     idle_timeout_ticks;
		logic [REFRESH_W-1:0]  refresh_period_ticks;
	} bpq_cfg_t;

	typedef struct packed {
		action_t action;
		logic    page;
		logic    refresh_pulse;
		logic    sleep_request;
		logic    debounced_level;
	} bpq_result_t;

endpackage

FILE: src/bpq_cfg_regs.sv
// ----------------------------------------------------------------------------
// bpq_cfg_regs
// configuration register file, written through a valid/ready channel
// ----------------------------------------------------------------------------
module bpq_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bpq_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [bpq_pkg::CFG_DATA_W-1:0]  cfg_data,
	output bpq_pkg::bpq_cfg_t              cfg
);
	import bpq_pkg::*;

	bpq_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks       <= DEBOUNCE_RESET;
			cfg_q.long_press_ticks     <= LONG_RESET;
			cfg_q.idle_timeout_ticks   <= IDLE_RESET;
			cfg_q.refresh_period_ticks <= REFRESH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_index_t'(cfg_index))
				REG_DEBOUNCE: cfg_q.debounce_ticks       <= cfg_data[DEBOUNCE_W-1:0];
				REG_LONG:     cfg_q.long_press_ticks     <= cfg_data[LONG_W-1:0];
				REG_IDLE:     cfg_q.idle_timeout_ticks   <= cfg_data[IDLE_W-1:0];
				REG_REFRESH:  cfg_q.refresh_period_ticks <= cfg_data[REFRESH_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

FILE: src/bpq_core.sv
// ----------------------------------------------------------------------------
// bpq_core
// qualifier state and the per-tick update: debounce, hold, refresh, idle
// ----------------------------------------------------------------------------
module bpq_core #(
	parameter int COUNT_WIDTH = bpq_pkg::COUNT_WIDTH_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic                 raw,
	input  bpq_pkg::bpq_cfg_t    cfg,
	output bpq_pkg::bpq_result_t result
);
	import bpq_pkg::*;

	localparam int CMP_W = (COUNT_WIDTH > IDLE_W) ? COUNT_WIDTH : IDLE_W;

	logic                   prev_raw_q;
	logic                   acc_level_q;
	logic [COUNT_WIDTH-1:0] stable_q;
	logic [COUNT_WIDTH-1:0] hold_q;
	logic                   hold_done_q;
	logic [COUNT_WIDTH-1:0] idle_q;
	logic [COUNT_WIDTH-1:0] refresh_q;
	logic                   page_q;

	logic [COUNT_WIDTH-1:0] stable_d, hold_d, idle_d, refresh_d;
	logic [COUNT_WIDTH-1:0] refresh_inc;
	logic                   acc_level_d, hold_done_d, page_d;
	logic                   accept_chg;
	logic                   pulse, sleep;
	action_t                act;

	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	always_comb begin
		stable_d    = (raw != prev_raw_q) ? '0 : sat_inc(stable_q);
		hold_d      = sat_inc(hold_q);
		idle_d      = sat_inc(idle_q);
		refresh_inc = sat_inc(refresh_q);
		refresh_d   = refresh_inc;
		acc_level_d = acc_level_q;
		hold_done_d = hold_done_q;
		page_d      = page_q;
		act         = ACT_NONE;
		pulse       = 1'b0;

		// debounced acceptance of a new level
		accept_chg = (CMP_W'(stable_d) > CMP_W'(cfg.debounce_ticks)) && (raw != acc_level_q);
		if (accept_chg) begin
			acc_level_d = raw;
			idle_d      = '0;
			if (raw == LVL_PRESSED) begin
				hold_d      = '0;
				hold_done_d = 1'b0;
			end else if (!hold_done_q) begin
				act    = (page_q == PAGE_HOME) ? ACT_ALERT : ACT_READY;
				page_d = PAGE_HOME;
			end
		end

		// long hold toggles the page once per press
		if (acc_level_d == LVL_PRESSED && !hold_done_d &&
		    CMP_W'(hold_d) >= CMP_W'(cfg.long_press_ticks)) begin
			page_d      = ~page_d;
			hold_done_d = 1'b1;
			idle_d      = '0;
			act         = ACT_TOGGLE;
		end

		if (page_d == PAGE_HOME && acc_level_d == LVL_RELEASED &&
		    CMP_W'(refresh_inc) > CMP_W'(cfg.refresh_period_ticks)) begin
			refresh_d = '0;
			pulse     = 1'b1;
		end

		sleep = (acc_level_d == LVL_RELEASED) &&
		        (CMP_W'(idle_d) > CMP_W'(cfg.idle_timeout_ticks));

		result.action          = act;
		result.page            = page_d;
		result.refresh_pulse   = pulse;
		result.sleep_request   = sleep;
		result.debounced_level = acc_level_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_raw_q  <= LVL_RELEASED;
			acc_level_q <= LVL_RELEASED;
			stable_q    <= '0;
			hold_q      <= '0;
			hold_done_q <= 1'b0;
			idle_q      <= '0;
			refresh_q   <= '0;
			page_q      <= PAGE_HOME;
		end else if (step) begin
			prev_raw_q  <= raw;
			acc_level_q <= acc_level_d;
			stable_q    <= stable_d;
			hold_q      <= hold_d;
			hold_done_q <= hold_done_d;
			idle_q      <= idle_d;
			refresh_q   <= refresh_d;
			page_q      <= page_d;
		end
	end

endmodule

FILE: src/button_press_qualifier_top.sv
// ----------------------------------------------------------------------------
// button_press_qualifier_top
// debounce, long-press, refresh and idle-timeout qualifier for one button
// ----------------------------------------------------------------------------
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------
//  sample   | sample_valid, sample_ready | raw_level
//  result   | result_valid, result_ready | action, page, refresh_pulse,
//           |                            | sleep_request, debounced_level
//  cfg      | cfg_valid, cfg_ready       | cfg_index, cfg_data
//
//  one request per cycle sustained while result_ready stays high; a result is
//  presented once its sample has passed the input register, then the update
//  logic into the result register
//  the stage-one update is the only path and is set by the counter compares
//  reset clears qualifier state and loads the register defaults at once
//  a stalled result holds the input stage; sample_ready stays high while the
//  result register drains or is free
//
module button_press_qualifier_top #(
	parameter int COUNT_WIDTH = bpq_pkg::COUNT_WIDTH_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// sample channel
	input  logic                            sample_valid,
	output logic                            sample_ready,
	input  logic                            raw_level,
	// result channel
	output logic                            result_valid,
	input  logic                            result_ready,
	output logic [1:0]                      action,
	output logic                            page,
	output logic                            refresh_pulse,
	output logic                            sleep_request,
	output logic                            debounced_level,
	// configuration channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bpq_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [bpq_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import bpq_pkg::*;

	bpq_cfg_t    cfg;
	bpq_result_t step_res;
	bpq_result_t res_q;

	// input stage
	logic valid_s1;
	logic raw_s1;
	// result register
	logic res_valid_q;

	logic advance;

	// stage one moves into the result register when that register is free
	// or being emptied in the same cycle
	assign advance      = valid_s1 && (!res_valid_q || result_ready);
	assign sample_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	// payload register, no reset needed
	always_ff @(posedge clk) begin
		if (sample_valid && sample_ready) begin
			raw_s1 <= raw_level;
		end
	end

	bpq_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// qualifier state only advances when the request leaves stage one
	bpq_core #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.raw    (raw_s1),
		.cfg    (cfg),
		.result (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= step_res;
		end
	end

	assign result_valid    = res_valid_q;
	assign action          = res_q.action;
	assign page            = res_q.page;
	assign refresh_pulse   = res_q.refresh_pulse;
	assign sleep_request   = res_q.sleep_request;
	assign debounced_level = res_q.debounced_level;

`ifndef SYNTHESIS
	// an empty result register never blocks a new sample
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid_q |-> sample_ready)
		else $error("sample_ready low with empty result register");

	// a loaded stage one with a stalled result keeps its request
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && res_valid_q && !result_ready) |=> valid_s1)
		else $error("stage one request lost under stall");

	// sleep only while released
	a_sleep_released: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && sleep_request) |-> (debounced_level == LVL_RELEASED))
		else $error("sleep request while pressed");

	// refresh only on the ready page while released
	a_refresh_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && refresh_pulse) |->
		(page == PAGE_HOME && debounced_level == LVL_RELEASED))
		else $error("refresh pulse outside ready page");

	// release actions always land on the ready page
	a_release_page: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (action == ACT_ALERT || action == ACT_READY)) |->
		(page == PAGE_HOME))
		else $error("release action left info page selected");
`endif

endmodule

FILE: verif/tb_button_press_qualifier_top.sv
// ----------------------------------------------------------------------------
// tb_button_press_qualifier_top
// self-checking bench for the button press qualifier: streams raw pin samples
// through the sample channel, predicts every result tick with its own model of
// debounce, long hold, refresh and idle timeout, and checks each returned
// result field by field under random stalls on both channels
// ----------------------------------------------------------------------------

// tracks register settings and qualifier state, keeps the predicted results
class press_result_board;

	// register copies
	logic [bpq_pkg::DEBOUNCE_W-1:0] deb_limit;
	logic [bpq_pkg::LONG_W-1:0]     long_limit;
	logic [bpq_pkg::IDLE_W-1:0]     idle_limit;
	logic [bpq_pkg::REFRESH_W-1:0]  refresh_limit;

	// qualifier state
	logic last_raw;
	logic level;
	logic held;
	logic page_sel;
	logic [bpq_pkg::COUNT_WIDTH_DEFAULT-1:0] stable_run;
	logic [bpq_pkg::COUNT_WIDTH_DEFAULT-1:0] hold_run;
	logic [bpq_pkg::COUNT_WIDTH_DEFAULT-1:0] idle_run;
	logic [bpq_pkg::COUNT_WIDTH_DEFAULT-1:0] refresh_run;

	bpq_pkg::bpq_result_t expected_ticks[$];

	int unsigned mismatches;
	int unsigned results_seen;
	int unsigned alerts;
	int unsigned returns;
	int unsigned toggles;
	int unsigned pulses;
	int unsigned sleeps;

	function new();
		deb_limit     = bpq_pkg::DEBOUNCE_RESET;
		long_limit    = bpq_pkg::LONG_RESET;
		idle_limit    = bpq_pkg::IDLE_RESET;
		refresh_limit = bpq_pkg::REFRESH_RESET;
		last_raw      = bpq_pkg::LVL_RELEASED;
		level         = bpq_pkg::LVL_RELEASED;
		held          = 1'b0;
		page_sel      = bpq_pkg::PAGE_HOME;
		stable_run    = '0;
		hold_run      = '0;
		idle_run      = '0;
		refresh_run   = '0;
		mismatches    = 0;
		results_seen  = 0;
		alerts        = 0;
		returns       = 0;
		toggles       = 0;
		pulses        = 0;
		sleeps        = 0;
	endfunction

	function void set_register(bpq_pkg::reg_index_t idx,
			logic [bpq_pkg::CFG_DATA_W-1:0] data);
		case (idx)
			bpq_pkg::REG_DEBOUNCE: deb_limit     = data[bpq_pkg::DEBOUNCE_W-1:0];
			bpq_pkg::REG_LONG:     long_limit    = data[bpq_pkg::LONG_W-1:0];
			bpq_pkg::REG_IDLE:     idle_limit    = data[bpq_pkg::IDLE_W-1:0];
			bpq_pkg::REG_REFRESH:  refresh_limit = data[bpq_pkg::REFRESH_W-1:0];
			default: ;
		endcase
	endfunction

	// saturating tick counter
	function logic [bpq_pkg::COUNT_WIDTH_DEFAULT-1:0] bump(
			logic [bpq_pkg::COUNT_WIDTH_DEFAULT-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	// one tick of the qualifier
	function bpq_pkg::bpq_result_t qualify_tick(logic raw);
		bpq_pkg::bpq_result_t r;
		r.action        = bpq_pkg::ACT_NONE;
		r.refresh_pulse = 1'b0;
		r.sleep_request = 1'b0;

		stable_run  = bump(stable_run);
		hold_run    = bump(hold_run);
		idle_run    = bump(idle_run);
		refresh_run = bump(refresh_run);

		if (raw != last_raw) begin
			stable_run = '0;
			last_raw   = raw;
		end

		// acceptance of a new level
		if (stable_run > deb_limit && raw != level) begin
			level    = raw;
			idle_run = '0;
			if (level == bpq_pkg::LVL_PRESSED) begin
				hold_run = '0;
				held     = 1'b0;
			end else if (!held) begin
				r.action = (page_sel == bpq_pkg::PAGE_HOME) ? bpq_pkg::ACT_ALERT
					: bpq_pkg::ACT_READY;
				page_sel = bpq_pkg::PAGE_HOME;
			end
		end

		// long hold flips the page once per press
		if (level == bpq_pkg::LVL_PRESSED && !held && hold_run >= long_limit) begin
			page_sel = ~page_sel;
			held     = 1'b1;
			idle_run = '0;
			r.action = bpq_pkg::ACT_TOGGLE;
		end

		if (page_sel == bpq_pkg::PAGE_HOME && level == bpq_pkg::LVL_RELEASED &&
				refresh_run > refresh_limit) begin
			refresh_run     = '0;
			r.refresh_pulse = 1'b1;
		end

		if (level == bpq_pkg::LVL_RELEASED && idle_run > idle_limit)
			r.sleep_request = 1'b1;

		r.page            = page_sel;
		r.debounced_level = level;
		return r;
	endfunction

	function void note_sample(logic raw);
		bpq_pkg::bpq_result_t r;
		r = qualify_tick(raw);
		case (r.action)
			bpq_pkg::ACT_ALERT:  alerts++;
			bpq_pkg::ACT_READY:  returns++;
			bpq_pkg::ACT_TOGGLE: toggles++;
			default: ;
		endcase
		if (r.refresh_pulse) pulses++;
		if (r.sleep_request) sleeps++;
		expected_ticks.push_back(r);
	endfunction

	task report(string what);
		if (mismatches < 40) $display("mismatch: %s", what);
		mismatches++;
	endtask

	task check_tick(logic [1:0] act, logic pg, logic pulse, logic slp, logic lvl);
		bpq_pkg::bpq_result_t want;
		if (expected_ticks.size() == 0) begin
			report($sformatf("result %0d came with no sample outstanding", results_seen));
		end else begin
			want = expected_ticks.pop_front();
			if (act !== want.action)
				report($sformatf("result %0d action %0d, predicted %0d",
					results_seen, act, want.action));
			if (pg !== want.page)
				report($sformatf("result %0d page %b, predicted %b",
					results_seen, pg, want.page));
			if (pulse !== want.refresh_pulse)
				report($sformatf("result %0d refresh_pulse %b, predicted %b",
					results_seen, pulse, want.refresh_pulse));
			if (slp !== want.sleep_request)
				report($sformatf("result %0d sleep_request %b, predicted %b",
					results_seen, slp, want.sleep_request));
			if (lvl !== want.debounced_level)
				report($sformatf("result %0d debounced_level %b, predicted %b",
					results_seen, lvl, want.debounced_level));
		end
		results_seen++;
	endtask

endclass

module tb_button_press_qualifier_top;

	import bpq_pkg::*;

	// quiet cycles tolerated before the watchdog gives up; well above the
	// longest legal lull (receiver squeeze plus a long gap on each side)
	localparam int unsigned QUIET_LIMIT    = 3000;
	// receiver hold-off long enough to back the pipe up into the sender
	localparam int unsigned SQUEEZE_CYCLES = 200;
	// a sample passes only the input and result registers, so a short tail is plenty
	localparam int unsigned TAIL_CYCLES    = 20;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// sample channel
	logic sample_valid = 1'b0;
	logic sample_ready;
	logic raw_level    = LVL_RELEASED;

	// result channel
	logic       result_valid;
	logic       result_ready = 1'b0;
	logic [1:0] action;
	logic       page;
	logic       refresh_pulse;
	logic       sleep_request;
	logic       debounced_level;

	// configuration channel
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	reg_index_t            cfg_index = REG_DEBOUNCE;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// knobs shared between the stimulus and the receiver
	logic steady_flow   = 1'b0;   // no idling on either side
	logic squeeze_armed = 1'b0;   // receiver does one long hold-off

	int unsigned samples_sent    = 0;
	int unsigned settings_loaded = 0;

	press_result_board press_board;

	button_press_qualifier_top dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.sample_valid    (sample_valid),
		.sample_ready    (sample_ready),
		.raw_level       (raw_level),
		.result_valid    (result_valid),
		.result_ready    (result_ready),
		.action          (action),
		.page            (page),
		.refresh_pulse   (refresh_pulse),
		.sleep_request   (sleep_request),
		.debounced_level (debounced_level),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int unsigned gap_length();
		if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	// offer one sample, hold it until the block takes it
	task automatic send_sample(input logic raw);
		int unsigned gap;
		gap = steady_flow ? 0 : ($urandom_range(0, 1) ? 0 : gap_length());
		if (gap != 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		raw_level    <= raw;
		@(posedge clk);
		while (!sample_ready) @(posedge clk);
		press_board.note_sample(raw);
		samples_sent++;
	endtask

	// msb first
	task automatic send_pattern(input logic [31:0] bits, input int count);
		for (int i = count - 1; i >= 0; i--) send_sample(bits[i]);
	endtask

	// sender goes quiet until every predicted result has come back
	task automatic drain();
		sample_valid <= 1'b0;
		do @(posedge clk); while (press_board.expected_ticks.size() != 0);
	endtask

	// write all four registers back to back, valid stays up between requests
	task automatic load_settings(input int unsigned deb, input int unsigned lng,
			input int unsigned idl, input int unsigned rfr);
		reg_index_t            order  [4];
		logic [CFG_DATA_W-1:0] values [4];
		order[0] = REG_DEBOUNCE; values[0] = CFG_DATA_W'(deb);
		order[1] = REG_LONG;     values[1] = CFG_DATA_W'(lng);
		order[2] = REG_IDLE;     values[2] = CFG_DATA_W'(idl);
		order[3] = REG_REFRESH;  values[3] = CFG_DATA_W'(rfr);
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= order[i];
			cfg_data  <= values[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			press_board.set_register(order[i], values[i]);
		end
		cfg_valid <= 1'b0;
		settings_loaded++;
	endtask

	// one press and release, sized from the current settings
	// mostly clean presses with bounce, some too short to qualify, some noise
	task automatic press_episode();
		int unsigned kind;
		int unsigned deb;
		int unsigned lng;
		int unsigned press_len;
		int unsigned rel_span;
		kind     = $urandom_range(0, 9);
		deb      = press_board.deb_limit;
		lng      = press_board.long_limit;
		rel_span = (press_board.idle_limit > 56) ? 60 : press_board.idle_limit + 4;
		if (kind == 9) begin
			repeat ($urandom_range(1, 8)) send_sample(1'($urandom_range(0, 1)));
		end else begin
			// contact bounce on the way down
			repeat ($urandom_range(0, 3)) begin
				send_sample(LVL_PRESSED);
				send_sample(LVL_RELEASED);
			end
			if (kind >= 7)
				press_len = $urandom_range(1, deb + 1);   // at or under the debounce
			else if ($urandom_range(0, 1))
				press_len = deb + 1 + $urandom_range(0, (lng == 0) ? 0 : lng - 1);
			else
				press_len = deb + 1 + lng + $urandom_range(0, 4);
			repeat (press_len) send_sample(LVL_PRESSED);
			// bounce on the way up
			repeat ($urandom_range(0, 2)) begin
				send_sample(LVL_RELEASED);
				send_sample(LVL_PRESSED);
			end
			repeat (deb + 1 + $urandom_range(0, rel_span)) send_sample(LVL_RELEASED);
		end
	endtask

	task automatic random_phase(input int unsigned count);
		int unsigned target;
		target = samples_sent + count;
		while (samples_sent < target) begin
			press_episode();
			// occasional full pause of the sender
			if ($urandom_range(0, 39) == 0) drain();
		end
	endtask

	// result side: random stalls, one long squeeze, or steady draining
	initial begin : receiver
		int unsigned stall_left;
		int unsigned squeeze_left;
		stall_left   = 0;
		squeeze_left = SQUEEZE_CYCLES;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (steady_flow) begin
				result_ready <= 1'b1;
			end else if (squeeze_armed && squeeze_left != 0) begin
				result_ready <= 1'b0;
				squeeze_left--;
			end else if (stall_left != 0) begin
				result_ready <= 1'b0;
				stall_left--;
			end else if ($urandom_range(0, 4) == 0) begin
				result_ready <= 1'b0;
				stall_left = gap_length() - 1;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// every accepted result goes against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			press_board.check_tick(action, page, refresh_pulse, sleep_request,
				debounced_level);
	end

	// give up once nothing has moved on any channel for too long
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((sample_valid && sample_ready) || (result_valid && result_ready) ||
					(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no request moved for %0d cycles", QUIET_LIMIT);
		$display("tb_button_press_qualifier_top: FAIL");
		$finish;
	end

	initial begin : stimulus
		int unsigned soak_start;
		press_board = new();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: debounce of 40 swallows a short blip
		send_pattern(32'b101, 3);
		drain();

		// zero debounce and zero long press: the toggle lands on the tick
		// the press is accepted, released hold gives no action, refresh and
		// sleep fire at their lowest thresholds
		load_settings(0, 0, 1, 1);
		send_pattern(32'b111_000_111, 9);
		drain();

		// glitch clears the stable run, short press on the info page returns
		// to ready, short press on the ready page sends an alert
		load_settings(1, 3, 4, 2);
		send_pattern(32'b01000_111_000_111, 14);
		drain();

		// random press traffic; the receiver squeezes once early on
		load_settings($urandom_range(0, 4), $urandom_range(1, 20),
			$urandom_range(1, 50), $urandom_range(1, 30));
		squeeze_armed <= 1'b1;
		random_phase(300);
		drain();

		// lowest legal thresholds
		load_settings(0, 1, 1, 1);
		random_phase(250);
		drain();

		// back-to-back traffic, no idling anywhere
		load_settings($urandom_range(0, 6), $urandom_range(1, 30),
			$urandom_range(1, 60), $urandom_range(1, 40));
		steady_flow <= 1'b1;
		random_phase(300);
		drain();
		steady_flow <= 1'b0;

		// long press threshold may be zero here
		load_settings($urandom_range(0, 6), $urandom_range(0, 25),
			$urandom_range(1, 60), $urandom_range(1, 40));
		random_phase(350);
		drain();

		// full-scale settings: a short press and release never qualifies
		// and no counter gets near its threshold
		soak_start = samples_sent;
		load_settings(1023, 65535, 20'hFFFFF, 65535);
		steady_flow <= 1'b1;
		repeat (30) send_sample(LVL_PRESSED);
		repeat (30) send_sample(LVL_RELEASED);
		drain();

		// idle timeout one below full scale, still out of reach
		load_settings(1023, 65535, 20'hFFFFE, 65535);
		repeat (4) send_sample(LVL_RELEASED);
		drain();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (press_board.expected_ticks.size() != 0)
			press_board.report($sformatf("%0d predicted results never came",
				press_board.expected_ticks.size()));

		$display("%0d samples under %0d register settings (%0d at full-scale settings)",
			samples_sent, settings_loaded, samples_sent - soak_start);
		$display("%0d alerts, %0d returns, %0d hold toggles, %0d refreshes, %0d sleep ticks",
			press_board.alerts, press_board.returns, press_board.toggles,
			press_board.pulses, press_board.sleeps);
		if (press_board.mismatches == 0)
			$display("tb_button_press_qualifier_top: PASS");
		else
			$display("tb_button_press_qualifier_top: FAIL");
		$finish;
	end

endmodule
